// ===== rtl/priority_thread_scheduler_defines.svh =====
// Assertion macros shared by the scheduler's checker.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef PRIORITY_THREAD_SCHEDULER_DEFINES_SVH
`define PRIORITY_THREAD_SCHEDULER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define PTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define PTS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pts_pkg.sv =====
// Package for the priority thread scheduler: field widths and request codes.
// No dependencies; used by the top level and its checker.
package pts_pkg;

    // Payload widths
    localparam int KIND_W     = 3;
    localparam int PRIO_W     = 3;
    localparam int TICKS_W    = 16;
    localparam int ID_W       = 16;
    localparam int SLOT_OUT_W = 4;
    localparam int MS_W       = 32;

    // First thread id handed out after reset
    localparam logic [ID_W-1:0] FIRST_ID = 16'd4;

    // Request codes
    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_KILL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SLEEP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SLICE = 3'd4;

endpackage

// ===== rtl/priority_thread_scheduler.sv =====
// Priority round-robin thread scheduler: one request in, one result out.
// Add scans for the lowest free slot; kill, sleep and slice rescan for the next thread
// (kill and sleep skip the scan when refused); tick sweeps sleep counts, then rescans when nothing was running.
// The slot scan visits one slot a cycle through the single read port of each slot memory.
// One request at a time; the next is taken while the previous result waits.
// Reset: synchronous, active low; clears used/ready marks, running state, tick count.
module priority_thread_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pts_pkg::KIND_W-1:0]     i_kind,
    input  logic [pts_pkg::PRIO_W-1:0]     i_new_priority,
    input  logic [pts_pkg::TICKS_W-1:0]    i_sleep_ticks,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_ok,
    output logic [pts_pkg::SLOT_OUT_W-1:0] o_added_slot,
    output logic [pts_pkg::ID_W-1:0]       o_added_id,
    output logic [pts_pkg::SLOT_OUT_W-1:0] o_running_slot,
    output logic                           o_idle,
    output logic [pts_pkg::MS_W-1:0]       o_ms_count
);
    import pts_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_PICK,
        S_TICK,
        S_DONE
    } t_state;

    // Control and scheduler state
    t_state              r_state;
    logic [SLOTS-1:0]    r_used;
    logic [SLOTS-1:0]    r_ready;
    logic [IDX_W-1:0]    r_run;
    logic                r_run_valid;
    logic [ID_W-1:0]     r_next_id;
    logic [MS_W-1:0]     r_ms;

    // Scan sequencer
    logic [CNT_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_ptr;
    logic                r_cmp_v;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_found;
    logic [IDX_W-1:0]    r_best;
    logic [PRIO_W-1:0]   r_best_prio;

    // Latched request and result
    logic [PRIO_W-1:0]   r_prio;
    logic                r_ok;
    logic [IDX_W-1:0]    r_add_slot;
    logic [ID_W-1:0]     r_add_id;

    // Output register
    logic                r_out_valid;
    logic                r_o_ok;
    logic [SLOT_OUT_W-1:0] r_o_add_slot;
    logic [ID_W-1:0]     r_o_add_id;
    logic [SLOT_OUT_W-1:0] r_o_run;
    logic                r_o_idle;
    logic [MS_W-1:0]     r_o_ms;

    // Slot memories: priority and sleep count
    logic [PRIO_W-1:0]   prio_mem  [SLOTS];
    logic [TICKS_W-1:0]  sleep_mem [SLOTS];
    logic [PRIO_W-1:0]   r_rd_prio;
    logic [TICKS_W-1:0]  r_rd_sleep;

    logic                in_acc;
    logic [IDX_W-1:0]    cnt_idx;
    logic                scan_end;
    logic                free_hit;
    logic                tick_hit;
    logic                pick_hit;
    logic [ID_W-1:0]     n_next_id;
    logic [IDX_W-1:0]    n_ptr_start;
    logic                sl_we;
    logic [IDX_W-1:0]    sl_waddr;
    logic [TICKS_W-1:0]  sl_wdata;
    logic                pr_we;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cnt_idx  = r_cnt[IDX_W-1:0];
    assign scan_end = (r_cnt == CNT_END);
    assign free_hit = !scan_end && !r_used[cnt_idx];
    assign tick_hit = r_cmp_v && r_used[r_cmp_idx] && !r_ready[r_cmp_idx]
                      && (r_rd_sleep != '0);
    assign pick_hit = r_cmp_v && r_ready[r_cmp_idx]
                      && (!r_found || (r_rd_prio < r_best_prio));

    // Id counter skips zero on wrap
    always_comb begin
        n_next_id = r_next_id + ID_W'(1);
        if (n_next_id == '0) begin
            n_next_id = ID_W'(1);
        end
    end

    // Scan starts at the slot after the running one
    assign n_ptr_start = (r_run == IDX_LAST) ? '0 : r_run + IDX_W'(1);

    // Memory write selection
    always_comb begin
        sl_we    = 1'b0;
        sl_waddr = r_run;
        sl_wdata = i_sleep_ticks;
        pr_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_kind == KIND_SLEEP && r_run_valid && i_sleep_ticks != '0) begin
                    sl_we = 1'b1;
                end
            end
            S_FREE: begin
                if (free_hit) begin
                    sl_we    = 1'b1;
                    sl_waddr = cnt_idx;
                    sl_wdata = '0;
                    pr_we    = 1'b1;
                end
            end
            S_TICK: begin
                if (tick_hit) begin
                    sl_we    = 1'b1;
                    sl_waddr = r_cmp_idx;
                    sl_wdata = r_rd_sleep - TICKS_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Priority memory: written on add, read by the scheduling scan
    always_ff @(posedge i_clk) begin
        if (pr_we) begin
            prio_mem[cnt_idx] <= r_prio;
        end
        r_rd_prio <= prio_mem[r_ptr];
    end

    // Sleep memory: written on add, sleep and tick, read by the tick sweep
    always_ff @(posedge i_clk) begin
        if (sl_we) begin
            sleep_mem[sl_waddr] <= sl_wdata;
        end
        r_rd_sleep <= sleep_mem[cnt_idx];
    end

    // Sequencer, scheduler state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_ready     <= '0;
            r_run       <= '0;
            r_run_valid <= 1'b0;
            r_next_id   <= FIRST_ID;
            r_ms        <= '0;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_cmp_v     <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Result beat taken; a new result loaded this cycle keeps it valid
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                // Take a request and do its single-slot updates
                S_IDLE: begin
                    if (in_acc) begin
                        r_prio     <= i_new_priority;
                        r_ok       <= 1'b0;
                        r_add_slot <= '0;
                        r_add_id   <= '0;
                        r_cnt      <= '0;
                        r_cmp_v    <= 1'b0;
                        r_found    <= 1'b0;
                        r_ptr      <= n_ptr_start;
                        unique case (i_kind)
                            KIND_ADD: begin
                                r_state <= S_FREE;
                            end
                            KIND_KILL: begin
                                if (r_run_valid) begin
                                    r_used[r_run]  <= 1'b0;
                                    r_ready[r_run] <= 1'b0;
                                    r_ok           <= 1'b1;
                                    r_state        <= S_PICK;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            KIND_SLEEP: begin
                                if (r_run_valid) begin
                                    if (i_sleep_ticks != '0) begin
                                        r_ready[r_run] <= 1'b0;
                                    end
                                    r_ok    <= 1'b1;
                                    r_state <= S_PICK;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            KIND_TICK: begin
                                r_ms    <= r_ms + MS_W'(1);
                                r_ok    <= 1'b1;
                                r_state <= S_TICK;
                            end
                            KIND_SLICE: begin
                                r_ok    <= 1'b1;
                                r_state <= S_PICK;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                // Lowest free slot, one slot a cycle
                S_FREE: begin
                    if (scan_end) begin
                        r_state <= S_DONE;
                    end else if (free_hit) begin
                        r_used[cnt_idx]  <= 1'b1;
                        r_ready[cnt_idx] <= 1'b1;
                        r_add_slot       <= cnt_idx;
                        r_add_id         <= r_next_id;
                        r_next_id        <= n_next_id;
                        r_ok             <= 1'b1;
                        if (!r_run_valid) begin
                            r_run       <= cnt_idx;
                            r_run_valid <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end

                // Best-priority ready slot: read stage then compare stage
                S_PICK: begin
                    if (!scan_end) begin
                        r_cmp_v   <= 1'b1;
                        r_cmp_idx <= r_ptr;
                        r_ptr     <= (r_ptr == IDX_LAST) ? '0 : r_ptr + IDX_W'(1);
                        r_cnt     <= r_cnt + CNT_W'(1);
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                    if (pick_hit) begin
                        r_found     <= 1'b1;
                        r_best      <= r_cmp_idx;
                        r_best_prio <= r_rd_prio;
                    end
                    if (scan_end && !r_cmp_v) begin
                        if (r_found) begin
                            r_run <= r_best;
                        end
                        r_run_valid <= r_found;
                        r_state     <= S_DONE;
                    end
                end

                // Sleep countdown sweep: read stage then write-back stage
                S_TICK: begin
                    if (!scan_end) begin
                        r_cmp_v   <= 1'b1;
                        r_cmp_idx <= cnt_idx;
                        r_cnt     <= r_cnt + CNT_W'(1);
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                    if (tick_hit && r_rd_sleep == TICKS_W'(1)) begin
                        r_ready[r_cmp_idx] <= 1'b1;
                    end
                    if (scan_end && !r_cmp_v) begin
                        if (r_run_valid) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cnt   <= '0;
                            r_found <= 1'b0;
                            r_ptr   <= n_ptr_start;
                            r_state <= S_PICK;
                        end
                    end
                end

                // Hand the result to the output register when it is free
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_o_ok       <= r_ok;
                        r_o_add_slot <= SLOT_OUT_W'(r_add_slot);
                        r_o_add_id   <= r_add_id;
                        r_o_run      <= SLOT_OUT_W'(r_run);
                        r_o_idle     <= !r_run_valid;
                        r_o_ms       <= r_ms;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_o_ok;
    assign o_added_slot   = r_o_add_slot;
    assign o_added_id     = r_o_add_id;
    assign o_running_slot = r_o_run;
    assign o_idle         = r_o_idle;
    assign o_ms_count     = r_o_ms;

endmodule

// ===== rtl/pts_checker.sv =====
// Port-level checker for the priority thread scheduler, bound to the top level.
// Depends on pts_pkg and priority_thread_scheduler_defines.svh.
`include "priority_thread_scheduler_defines.svh"

module pts_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_ok,
    input logic [pts_pkg::SLOT_OUT_W-1:0] o_added_slot,
    input logic [pts_pkg::ID_W-1:0]       o_added_id,
    input logic [pts_pkg::MS_W-1:0]       o_ms_count
);
    import pts_pkg::*;

    // One request at a time: taking a beat drops ready the next cycle
    `PTS_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready held after a request beat")

    // A failed request reports no slot and no id
    `PTS_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, o_out_valid && !o_ok, o_added_slot == '0 && o_added_id == ID_W'(0), "failed result carries add fields")

    // No result right after reset
    `PTS_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result valid out of reset")

    // A stalled result keeps its tick count
    `PTS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_ms_count), "stalled result changed")

endmodule

bind priority_thread_scheduler pts_checker u_pts_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_ok         (o_ok),
    .o_added_slot (o_added_slot),
    .o_added_id   (o_added_id),
    .o_ms_count   (o_ms_count)
);
